FILE: rtl/cscv_pkg.sv
`timescale 1ns / 1ps
// Package for the calendar seconds converter: shared constants, the control
// struct of the shared add/subtract unit and the calendar table functions.
// No dependencies.
package cscv_pkg;

   localparam logic [11:0] YEAR_BASE      = 12'd2000;
   localparam logic [11:0] YEAR_LAST      = 12'd2099;
   localparam logic [6:0]  YEAR_SPAN      = 7'd100;
   localparam logic [31:0] END_SECONDS    = 32'd3155760000;
   localparam logic [31:0] LEAP_YEAR_SECS = 32'd31622400;
   localparam logic [31:0] NORM_YEAR_SECS = 32'd31536000;
   localparam logic [31:0] DAY_SECS       = 32'd86400;
   localparam logic [31:0] HOUR_SECS      = 32'd3600;
   localparam logic [31:0] MIN_SECS       = 32'd60;
   localparam logic [2:0]  WD_START       = 3'd6;
   localparam logic [2:0]  WD_SUNDAY      = 3'd7;
   localparam logic [2:0]  WD_LEAP_STEP   = 3'd2;
   localparam logic [2:0]  WD_NORM_STEP   = 3'd1;
   localparam logic [3:0]  LAST_MONTH_IDX = 4'd11;

   typedef struct packed {
      logic load;
      logic step;
      logic sub;
   } alu_ctrl_type;

   function automatic logic [4:0] month_days(input logic leap, input logic [3:0] idx);
      logic [4:0] d;
      case (idx)
         4'd1:    d = leap ? 5'd29 : 5'd28;
         4'd3:    d = 5'd30;
         4'd5:    d = 5'd30;
         4'd8:    d = 5'd30;
         4'd10:   d = 5'd30;
         default: d = 5'd31;
      endcase
      return d;
   endfunction

   function automatic logic [31:0] month_secs(input logic leap, input logic [3:0] idx);
      return {27'd0, month_days(leap, idx)} * DAY_SECS;
   endfunction

   // month length mod 7: 31 -> 3, 30 -> 2, 29 -> 1, 28 -> 0
   function automatic logic [2:0] month_wd(input logic leap, input logic [3:0] idx);
      logic [2:0] w;
      case (month_days(leap, idx))
         5'd28:   w = 3'd0;
         5'd29:   w = 3'd1;
         5'd30:   w = 3'd2;
         default: w = 3'd3;
      endcase
      return w;
   endfunction

   // 2^k mod 7, for k from 0 to 5
   function automatic logic [2:0] pow2_mod7(input logic [2:0] k);
      logic [2:0] w;
      case (k)
         3'd0:    w = 3'd1;
         3'd1:    w = 3'd2;
         3'd2:    w = 3'd4;
         3'd3:    w = 3'd1;
         3'd4:    w = 3'd2;
         default: w = 3'd4;
      endcase
      return w;
   endfunction

   function automatic logic [2:0] wd_add(input logic [2:0] a, input logic [2:0] b);
      logic [3:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
   endfunction

endpackage

FILE: rtl/cscv_alu.sv
`timescale 1ns / 1ps
// Shared 32-bit accumulator with add/subtract and compare.
// Depends on cscv_pkg for the control struct.
module cscv_alu (
   input  logic                  clock,
   input  cscv_pkg::alu_ctrl_type ctrl,
   input  logic [31:0]           load_value,
   input  logic [31:0]           operand,
   output logic [31:0]           acc,
   output logic                  fits
);
   import cscv_pkg::*;

   logic [31:0] acc_ff;
   logic [31:0] acc_in;

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.load) begin
         acc_in = load_value;
      end else if (ctrl.step) begin
         acc_in = ctrl.sub ? (acc_ff - operand) : (acc_ff + operand);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc  = acc_ff;
   assign fits = (acc_ff >= operand);

endmodule

FILE: rtl/calendar_seconds_converter.sv
`timescale 1ns / 1ps
// Calendar seconds converter, top level: request capture, sequencer, result register.
// Depends on cscv_pkg and cscv_alu.
// The year walk (one add or subtract per year) and the month walk dominate, then five/five/six
// bit-serial steps for day, hour and minute, all on the one shared adder.
// One request at a time; req_ready is high only while the sequencer is idle.
// Synchronous active-high reset clears the sequencer and the response valid (rsp_valid).
module calendar_seconds_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [11:0] req_year_in,
   input  logic [3:0]  req_month_in,
   input  logic [4:0]  req_day_in,
   input  logic [4:0]  req_hour_in,
   input  logic [5:0]  req_minute_in,
   input  logic [5:0]  req_second_in,
   input  logic [31:0] req_seconds_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_valid_res,
   output logic [31:0] rsp_seconds_out,
   output logic [2:0]  rsp_weekday,
   output logic [11:0] rsp_year_out,
   output logic [3:0]  rsp_month_out,
   output logic [4:0]  rsp_day_out,
   output logic [4:0]  rsp_hour_out,
   output logic [5:0]  rsp_minute_out,
   output logic [5:0]  rsp_second_out
);
   import cscv_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_YEAR  = 3'd1;
   localparam logic [2:0] S_MONTH = 3'd2;
   localparam logic [2:0] S_DAY   = 3'd3;
   localparam logic [2:0] S_HOUR  = 3'd4;
   localparam logic [2:0] S_MIN   = 3'd5;
   localparam logic [2:0] S_SEC   = 3'd6;
   localparam logic [2:0] S_FIN   = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic        act_ff, act_in;
   logic        ok_ff, ok_in;
   logic [6:0]  yr_ff, yr_in;
   logic [6:0]  yr_tgt_ff, yr_tgt_in;
   logic [3:0]  mon_ff, mon_in;
   logic [3:0]  m_ff, m_in;
   logic [4:0]  day_ff, day_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  min_ff, min_in;
   logic [5:0]  sec_ff, sec_in;
   logic [31:0] secs_ff, secs_in;
   logic [2:0]  wd_ff, wd_in;
   logic [2:0]  bit_ff, bit_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        res_valid_ff;
   logic [31:0] res_seconds_ff;
   logic [2:0]  res_weekday_ff;
   logic [11:0] res_year_ff;
   logic [3:0]  res_month_ff;
   logic [4:0]  res_day_ff;
   logic [4:0]  res_hour_ff;
   logic [5:0]  res_minute_ff;
   logic [5:0]  res_second_ff;
   logic        res_load;

   alu_ctrl_type alu_ctrl;
   logic [31:0]  alu_load_value;
   logic [31:0]  alu_operand;
   logic [31:0]  acc;
   logic         fits;

   logic        accept;
   logic [11:0] yr_off;
   logic        leap_in;
   logic        ok0;
   logic        ok1;
   logic        leap;
   logic        take;

   cscv_alu u_alu (
      .clock      (clock),
      .ctrl       (alu_ctrl),
      .load_value (alu_load_value),
      .operand    (alu_operand),
      .acc        (acc),
      .fits       (fits)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   assign yr_off  = req_year_in - YEAR_BASE;
   assign leap_in = (req_year_in[1:0] == 2'b00);
   assign ok0 = (req_second_in <= 6'd59) && (req_minute_in <= 6'd59) &&
                (req_hour_in <= 5'd23) && (req_month_in >= 4'd1) &&
                (req_month_in <= 4'd12) && (req_year_in >= YEAR_BASE) &&
                (req_year_in <= YEAR_LAST) && (req_day_in >= 5'd1) &&
                (req_day_in <= month_days(leap_in, req_month_in - 4'd1));
   assign ok1  = (req_seconds_in < END_SECONDS);
   assign leap = (yr_ff[1:0] == 2'b00);

   always_comb begin
      state_in       = state_ff;
      act_in         = act_ff;
      ok_in          = ok_ff;
      yr_in          = yr_ff;
      yr_tgt_in      = yr_tgt_ff;
      mon_in         = mon_ff;
      m_in           = m_ff;
      day_in         = day_ff;
      hour_in        = hour_ff;
      min_in         = min_ff;
      sec_in         = sec_ff;
      secs_in        = secs_ff;
      wd_in          = wd_ff;
      bit_in         = bit_ff;
      alu_ctrl       = '0;
      alu_ctrl.sub   = act_ff;
      alu_load_value = 32'd0;
      alu_operand    = 32'd0;
      res_load       = 1'b0;
      take           = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in         = req_action;
               ok_in          = req_action ? ok1 : ok0;
               yr_in          = 7'd0;
               yr_tgt_in      = yr_off[6:0];
               mon_in         = req_month_in;
               m_in           = 4'd0;
               day_in         = req_action ? 5'd0 : (req_day_in - 5'd1);
               hour_in        = req_action ? 5'd0 : req_hour_in;
               min_in         = req_action ? 6'd0 : req_minute_in;
               sec_in         = req_second_in;
               secs_in        = req_seconds_in;
               wd_in          = WD_START;
               bit_in         = 3'd4;
               alu_ctrl.load  = 1'b1;
               alu_load_value = req_action ? req_seconds_in : 32'd0;
               state_in       = (req_action ? ok1 : ok0) ? S_YEAR : S_FIN;
            end
         end
         S_YEAR: begin
            alu_operand = leap ? LEAP_YEAR_SECS : NORM_YEAR_SECS;
            take = act_ff ? fits : (yr_ff != yr_tgt_ff);
            if (take) begin
               alu_ctrl.step = 1'b1;
               yr_in = yr_ff + 7'd1;
               wd_in = wd_add(wd_ff, leap ? WD_LEAP_STEP : WD_NORM_STEP);
            end else begin
               state_in = S_MONTH;
            end
         end
         S_MONTH: begin
            alu_operand = month_secs(leap, m_ff);
            take = act_ff ? (fits && (m_ff != LAST_MONTH_IDX)) : ((m_ff + 4'd1) != mon_ff);
            if (take) begin
               alu_ctrl.step = 1'b1;
               m_in  = m_ff + 4'd1;
               wd_in = wd_add(wd_ff, month_wd(leap, m_ff));
            end else begin
               state_in = S_DAY;
               bit_in   = 3'd4;
            end
         end
         S_DAY: begin
            alu_operand = DAY_SECS << bit_ff;
            take = act_ff ? fits : day_ff[bit_ff];
            if (take) begin
               alu_ctrl.step = 1'b1;
               wd_in = wd_add(wd_ff, pow2_mod7(bit_ff));
               if (act_ff) begin
                  day_in[bit_ff] = 1'b1;
               end
            end
            if (bit_ff == 3'd0) begin
               state_in = S_HOUR;
               bit_in   = 3'd4;
            end else begin
               bit_in = bit_ff - 3'd1;
            end
         end
         S_HOUR: begin
            alu_operand = HOUR_SECS << bit_ff;
            take = act_ff ? fits : hour_ff[bit_ff];
            if (take) begin
               alu_ctrl.step = 1'b1;
               if (act_ff) begin
                  hour_in[bit_ff] = 1'b1;
               end
            end
            if (bit_ff == 3'd0) begin
               state_in = S_MIN;
               bit_in   = 3'd5;
            end else begin
               bit_in = bit_ff - 3'd1;
            end
         end
         S_MIN: begin
            alu_operand = MIN_SECS << bit_ff;
            take = act_ff ? fits : min_ff[bit_ff];
            if (take) begin
               alu_ctrl.step = 1'b1;
               if (act_ff) begin
                  min_in[bit_ff] = 1'b1;
               end
            end
            if (bit_ff == 3'd0) begin
               state_in = act_ff ? S_FIN : S_SEC;
            end else begin
               bit_in = bit_ff - 3'd1;
            end
         end
         S_SEC: begin
            alu_operand   = {26'd0, sec_ff};
            alu_ctrl.step = 1'b1;
            state_in      = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               res_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      ok_ff     <= ok_in;
      yr_ff     <= yr_in;
      yr_tgt_ff <= yr_tgt_in;
      mon_ff    <= mon_in;
      m_ff      <= m_in;
      day_ff    <= day_in;
      hour_ff   <= hour_in;
      min_ff    <= min_in;
      sec_ff    <= sec_in;
      secs_ff   <= secs_in;
      wd_ff     <= wd_in;
      bit_ff    <= bit_in;
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         res_valid_ff   <= ok_ff;
         res_seconds_ff <= !ok_ff ? 32'd0 : (act_ff ? secs_ff : acc);
         res_weekday_ff <= (wd_ff == 3'd0) ? WD_SUNDAY : wd_ff;
         if (ok_ff && act_ff) begin
            res_year_ff   <= YEAR_BASE + {5'd0, yr_ff};
            res_month_ff  <= m_ff + 4'd1;
            res_day_ff    <= day_ff + 5'd1;
            res_hour_ff   <= hour_ff;
            res_minute_ff <= min_ff;
            res_second_ff <= acc[5:0];
         end else begin
            res_year_ff   <= 12'd0;
            res_month_ff  <= 4'd0;
            res_day_ff    <= 5'd0;
            res_hour_ff   <= 5'd0;
            res_minute_ff <= 6'd0;
            res_second_ff <= 6'd0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_valid_res   = res_valid_ff;
   assign rsp_seconds_out = res_seconds_ff;
   assign rsp_weekday     = res_weekday_ff;
   assign rsp_year_out    = res_year_ff;
   assign rsp_month_out   = res_month_ff;
   assign rsp_day_out     = res_day_ff;
   assign rsp_hour_out    = res_hour_ff;
   assign rsp_minute_out  = res_minute_ff;
   assign rsp_second_out  = res_second_ff;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> (rsp_seconds_out == 32'd0) && (rsp_weekday == WD_START))
      else $error("invalid result carries nonzero seconds or wrong weekday");

   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_weekday != 3'd0))
      else $error("weekday code zero on result");

   a_year_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_YEAR) |-> (yr_ff < YEAR_SPAN))
      else $error("year walk ran past the calendar range");

   a_month_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MONTH) |-> (m_ff <= LAST_MONTH_IDX))
      else $error("month walk ran past December");

endmodule

FILE: tb/calendar_seconds_converter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for calendar_seconds_converter: directed calendar corner cases,
// then random date and seconds requests under varying valid/ready idling.
// Needs the calendar_seconds_converter RTL with cscv_pkg and cscv_alu; results are checked against a local model.
module calendar_seconds_converter_tb;

   typedef enum logic { ACT_TO_SECONDS = 1'b0, ACT_TO_CALENDAR = 1'b1 } action_e;

   typedef struct packed {
      action_e     action;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [31:0] seconds;
   } request_t;

   typedef struct packed {
      logic        valid_res;
      logic [31:0] seconds;
      logic [2:0]  weekday;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } calendar_rsp_t;

   typedef struct {
      request_t      req;
      bit            typed;
      calendar_rsp_t result;
   } stim_row_t;

   localparam int unsigned   FIRST_YEAR   = 2000;
   localparam int unsigned   END_YEAR     = 2100;
   localparam logic [31:0]   END_SECONDS  = 32'd3155760000;
   localparam logic [31:0]   LAST_SECOND  = 32'd3155759999;
   localparam int unsigned   DAY_SECS     = 86400;
   localparam int unsigned   HOUR_SECS    = 3600;
   localparam int unsigned   MINUTE_SECS  = 60;
   localparam logic [2:0]    THURSDAY     = 3'd4;
   localparam logic [2:0]    SATURDAY     = 3'd6;
   localparam logic [2:0]    SUNDAY       = 3'd7;
   localparam int unsigned   RANDOM_ITEMS = 1000;
   localparam int unsigned   HOLD_CYCLES  = 400;
   localparam int unsigned   DRAIN_CYCLES = 200;
   localparam calendar_rsp_t REJECTED     = {1'b0, 32'd0, SATURDAY, 38'd0};

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_action;
   logic [11:0] req_year_in;
   logic [3:0]  req_month_in;
   logic [4:0]  req_day_in;
   logic [4:0]  req_hour_in;
   logic [5:0]  req_minute_in;
   logic [5:0]  req_second_in;
   logic [31:0] req_seconds_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_valid_res;
   logic [31:0] rsp_seconds_out;
   logic [2:0]  rsp_weekday;
   logic [11:0] rsp_year_out;
   logic [3:0]  rsp_month_out;
   logic [4:0]  rsp_day_out;
   logic [4:0]  rsp_hour_out;
   logic [5:0]  rsp_minute_out;
   logic [5:0]  rsp_second_out;

   calendar_rsp_t pending_results[$];
   int unsigned   send_idle_pct = 0;
   int unsigned   recv_idle_pct = 0;
   bit            hold_request  = 1'b0;
   bit            hold_done     = 1'b0;
   int unsigned   mismatch_count = 0;

   calendar_seconds_converter DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_year_in     (req_year_in),
      .req_month_in    (req_month_in),
      .req_day_in      (req_day_in),
      .req_hour_in     (req_hour_in),
      .req_minute_in   (req_minute_in),
      .req_second_in   (req_second_in),
      .req_seconds_in  (req_seconds_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_valid_res   (rsp_valid_res),
      .rsp_seconds_out (rsp_seconds_out),
      .rsp_weekday     (rsp_weekday),
      .rsp_year_out    (rsp_year_out),
      .rsp_month_out   (rsp_month_out),
      .rsp_day_out     (rsp_day_out),
      .rsp_hour_out    (rsp_hour_out),
      .rsp_minute_out  (rsp_minute_out),
      .rsp_second_out  (rsp_second_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // month is 1..12; every year divisible by 4 is a leap year
   function automatic logic [4:0] month_length(input logic [11:0] year, input logic [3:0] month);
      case (month)
         4'd2:                    month_length = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: month_length = 5'd30;
         default:                 month_length = 5'd31;
      endcase
   endfunction

   function automatic logic [31:0] year_length(input logic [11:0] year);
      year_length = (year[1:0] == 2'b00) ? 32'd31622400 : 32'd31536000;
   endfunction

   // day 0 is a Saturday
   function automatic logic [2:0] day_of_week(input logic [31:0] secs);
      int unsigned w;
      w = (secs / DAY_SECS + 6) % 7;
      day_of_week = (w == 0) ? SUNDAY : 3'(w);
   endfunction

   function automatic calendar_rsp_t convert_calendar(input request_t r);
      calendar_rsp_t res;
      logic [31:0]   total;
      logic [31:0]   rest;
      logic [11:0]   yr;
      logic [3:0]    mo;
      logic          ok;
      res = REJECTED;
      if (r.action == ACT_TO_SECONDS) begin
         ok = r.second <= 6'd59 && r.minute <= 6'd59 && r.hour <= 5'd23 &&
              r.month >= 4'd1 && r.month <= 4'd12 &&
              r.year >= 12'(FIRST_YEAR) && r.year < 12'(END_YEAR) && r.day >= 5'd1;
         if (ok && r.day > month_length(r.year, r.month))
            ok = 1'b0;
         total = '0;
         if (ok) begin
            for (yr = 12'(FIRST_YEAR); yr < r.year; yr++)
               total += year_length(yr);
            for (mo = 4'd1; mo < r.month; mo++)
               total += month_length(r.year, mo) * DAY_SECS;
            total += (32'(r.day) - 1) * DAY_SECS + 32'(r.hour) * HOUR_SECS
                     + 32'(r.minute) * MINUTE_SECS + 32'(r.second);
         end
         res.valid_res = ok;
         res.seconds   = total;
         res.weekday   = day_of_week(total);
      end else if (r.seconds < END_SECONDS) begin
         rest = r.seconds;
         yr   = 12'(FIRST_YEAR);
         while (yr < 12'(END_YEAR) && rest >= year_length(yr)) begin
            rest -= year_length(yr);
            yr++;
         end
         mo = 4'd1;
         while (mo < 4'd12 && rest >= month_length(yr, mo) * DAY_SECS) begin
            rest -= month_length(yr, mo) * DAY_SECS;
            mo++;
         end
         res.valid_res = 1'b1;
         res.seconds   = r.seconds;
         res.weekday   = day_of_week(r.seconds);
         res.year      = yr;
         res.month     = mo;
         res.day       = 5'(rest / DAY_SECS + 1);
         rest          = rest % DAY_SECS;
         res.hour      = 5'(rest / HOUR_SECS);
         rest          = rest % HOUR_SECS;
         res.minute    = 6'(rest / MINUTE_SECS);
         res.second    = 6'(rest % MINUTE_SECS);
      end
      return res;
   endfunction

   // seconds_in is don't-care here, so it gets random content
   function automatic request_t date_req(input logic [11:0] y, input logic [3:0] mo,
                                         input logic [4:0] d, input logic [4:0] h,
                                         input logic [5:0] mi, input logic [5:0] s);
      request_t r;
      r.action  = ACT_TO_SECONDS;
      r.year    = y;
      r.month   = mo;
      r.day     = d;
      r.hour    = h;
      r.minute  = mi;
      r.second  = s;
      r.seconds = $urandom;
      return r;
   endfunction

   // date fields are don't-care here
   function automatic request_t seconds_req(input logic [31:0] secs);
      request_t r;
      r.action  = ACT_TO_CALENDAR;
      r.year    = 12'($urandom);
      r.month   = 4'($urandom);
      r.day     = 5'($urandom);
      r.hour    = 5'($urandom);
      r.minute  = 6'($urandom);
      r.second  = 6'($urandom);
      r.seconds = secs;
      return r;
   endfunction

   function automatic calendar_rsp_t calendar_rsp(input logic ok, input logic [31:0] secs,
                                                  input logic [2:0] wd, input logic [11:0] y,
                                                  input logic [3:0] mo, input logic [4:0] d,
                                                  input logic [4:0] h, input logic [5:0] mi,
                                                  input logic [5:0] s);
      return {ok, secs, wd, y, mo, d, h, mi, s};
   endfunction

   function automatic stim_row_t make_row(input request_t r, input bit typed,
                                          input calendar_rsp_t result);
      stim_row_t row;
      row.req    = r;
      row.typed  = typed;
      row.result = result;
      return row;
   endfunction

   function automatic request_t random_request();
      int unsigned roll;
      logic [11:0] y;
      logic [3:0]  mo;
      logic [4:0]  d;
      request_t    r;
      roll = $urandom_range(99);
      y    = 12'(FIRST_YEAR + $urandom_range(99));
      mo   = 4'($urandom_range(12, 1));
      d    = ($urandom_range(3) == 0) ? month_length(y, mo)
                                      : 5'($urandom_range(month_length(y, mo), 1));
      r    = date_req(y, mo, d, 5'($urandom_range(23)), 6'($urandom_range(59)),
                      6'($urandom_range(59)));
      if (roll < 40) begin
         // well-formed date, kept as built
      end else if (roll < 55) begin
         // just around a midnight
         r = seconds_req(convert_calendar(date_req(y, mo, d, 5'd0, 6'd0, 6'd0)).seconds
                         + 32'($urandom_range(2)) - 32'd1);
      end else if (roll < 75) begin
         r = seconds_req($urandom_range(LAST_SECOND));
      end else if (roll < 83) begin
         r = seconds_req($urandom_range(32'hFFFF_FFFF, END_SECONDS));
      end else if (roll < 92) begin
         // one field pushed out of range
         case ($urandom_range(5))
            0:       r.year   = $urandom_range(1) ? 12'($urandom_range(FIRST_YEAR - 1))
                                                  : 12'($urandom_range(4095, END_YEAR));
            1:       r.month  = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 13));
            2:       r.day    = $urandom_range(1) ? 5'd0
                                : 5'($urandom_range(31, month_length(y, mo) + 1));
            3:       r.hour   = 5'($urandom_range(31, 24));
            4:       r.minute = 6'($urandom_range(63, 60));
            default: r.second = 6'($urandom_range(63, 60));
         endcase
      end else begin
         r.action  = action_e'($urandom_range(1));
         r.year    = 12'($urandom);
         r.month   = 4'($urandom);
         r.day     = 5'($urandom);
         r.hour    = 5'($urandom);
         r.minute  = 6'($urandom);
         r.second  = 6'($urandom);
         r.seconds = $urandom;
      end
      return r;
   endfunction

   task automatic drive_fields(input request_t r);
      req_action     <= r.action;
      req_year_in    <= r.year;
      req_month_in   <= r.month;
      req_day_in     <= r.day;
      req_hour_in    <= r.hour;
      req_minute_in  <= r.minute;
      req_second_in  <= r.second;
      req_seconds_in <= r.seconds;
   endtask

   task automatic send_request(input request_t r, input bit typed, input calendar_rsp_t result);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      drive_fields(r);
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      pending_results.push_back(typed ? result : convert_calendar(r));
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   initial begin
      stim_row_t directed_rows[$];
      reset     <= 1'b1;
      req_valid <= 1'b0;
      drive_fields('0);

      directed_rows.push_back(make_row(date_req(12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0), 1'b1,
         calendar_rsp(1'b1, 32'd0, SATURDAY, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0)));
      directed_rows.push_back(make_row(seconds_req(32'd0), 1'b1,
         calendar_rsp(1'b1, 32'd0, SATURDAY, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0)));
      directed_rows.push_back(make_row(date_req(12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59),
         1'b1, calendar_rsp(1'b1, LAST_SECOND, THURSDAY, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0)));
      directed_rows.push_back(make_row(seconds_req(LAST_SECOND), 1'b1,
         calendar_rsp(1'b1, LAST_SECOND, THURSDAY, 12'd2099, 4'd12, 5'd31, 5'd23, 6'd59,
                      6'd59)));
      directed_rows.push_back(make_row(seconds_req(END_SECONDS), 1'b1, REJECTED));
      directed_rows.push_back(make_row(seconds_req(32'hFFFF_FFFF), 1'b1, REJECTED));
      directed_rows.push_back(make_row(date_req(12'd2001, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0),
                                       1'b1, REJECTED));
      directed_rows.push_back(make_row(date_req(12'd2004, 4'd2, 5'd30, 5'd0, 6'd0, 6'd0),
                                       1'b1, REJECTED));
      directed_rows.push_back(make_row(date_req(12'd2023, 4'd4, 5'd31, 5'd0, 6'd0, 6'd0),
                                       1'b1, REJECTED));
      directed_rows.push_back(make_row(date_req(12'd1999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59),
                                       1'b1, REJECTED));
      directed_rows.push_back(make_row(date_req(12'd2100, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0),
                                       1'b1, REJECTED));
      directed_rows.push_back(make_row(date_req(12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63),
                                       1'b1, REJECTED));
      directed_rows.push_back(make_row(date_req(12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0),
                                       1'b1, REJECTED));
      directed_rows.push_back(make_row(date_req(12'd2010, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0),
                                       1'b1, REJECTED));
      directed_rows.push_back(make_row(date_req(12'd2010, 4'd5, 5'd0, 5'd0, 6'd0, 6'd0),
                                       1'b1, REJECTED));
      directed_rows.push_back(make_row(date_req(12'd2010, 4'd5, 5'd5, 5'd24, 6'd0, 6'd0),
                                       1'b1, REJECTED));
      directed_rows.push_back(make_row(date_req(12'd2010, 4'd5, 5'd5, 5'd0, 6'd60, 6'd0),
                                       1'b1, REJECTED));
      directed_rows.push_back(make_row(date_req(12'd2010, 4'd5, 5'd5, 5'd0, 6'd0, 6'd60),
                                       1'b1, REJECTED));
      directed_rows.push_back(make_row(date_req(12'd2000, 4'd2, 5'd29, 5'd12, 6'd30, 6'd45),
                                       1'b0, REJECTED));
      directed_rows.push_back(make_row(date_req(12'd2024, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59),
                                       1'b0, REJECTED));
      directed_rows.push_back(make_row(date_req(12'd2050, 4'd6, 5'd15, 5'd8, 6'd7, 6'd6),
                                       1'b0, REJECTED));
      directed_rows.push_back(make_row(seconds_req(32'd31622399), 1'b0, REJECTED));
      directed_rows.push_back(make_row(seconds_req(32'd31622400), 1'b0, REJECTED));
      directed_rows.push_back(make_row(seconds_req(32'd59 * DAY_SECS), 1'b0, REJECTED));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 35;
      recv_idle_pct = 58;
      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].result);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3) begin
            send_idle_pct = 58;
            recv_idle_pct = 35;
         end else if (i == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            hold_request  = 1'b1;
         end
         send_request(random_request(), 1'b0, REJECTED);
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("calendar_seconds_converter_tb: PASS");
      end else begin
         $display("calendar_seconds_converter_tb: FAIL");
      end
      $finish;
   end

   // result side; one long hold-off once the last phase starts
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
         @(posedge clock);
      end
   end

   always @(posedge clock) begin : result_check
      calendar_rsp_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result transfer with no request outstanding", $time);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("valid_res", want.valid_res, rsp_valid_res);
            check_field("seconds_out", want.seconds, rsp_seconds_out);
            check_field("weekday", want.weekday, rsp_weekday);
            check_field("year_out", want.year, rsp_year_out);
            check_field("month_out", want.month, rsp_month_out);
            check_field("day_out", want.day, rsp_day_out);
            check_field("hour_out", want.hour, rsp_hour_out);
            check_field("minute_out", want.minute, rsp_minute_out);
            check_field("second_out", want.second, rsp_second_out);
         end
      end
   end

   initial begin
      #15_000_000;
      $display("calendar_seconds_converter_tb: FAIL");
      $finish;
   end

endmodule
